// ===== rtl/ordered_list_positional_edit_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ordered list positional edit - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITIONAL_EDIT_TOP_DEFINES_SVH
`define ORDERED_LIST_POSITIONAL_EDIT_TOP_DEFINES_SVH

// same-cycle implication
`define OLPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/olpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list positional edit - package
// Field widths, edit codes and result status codes.
// ----------------------------------------------------------------------------
package olpe_pkg;

    localparam int ACTION_W     = 3;
    localparam int POS_W        = 6;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 6;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        A_PUSH_FRONT = 3'd0,
        A_PUSH_REAR  = 3'd1,
        A_POP_FRONT  = 3'd2,
        A_POP_REAR   = 3'd3,
        A_INSERT_AT  = 3'd4,
        A_REMOVE_AT  = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_POS   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// ===== rtl/olpe_ifs.sv =====
// ----------------------------------------------------------------------------
// Ordered list positional edit - channel interfaces
// Valid/ready channels for edit requests and edit results.
// ----------------------------------------------------------------------------
interface olpe_in_if
    import olpe_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]   position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface olpe_out_if
    import olpe_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [LEN_W-1:0]   length;

    modport source (output valid, output status, output removed_value, output length,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input length,
                    output ready);
endinterface

// ===== rtl/ordered_list_positional_edit_top.sv =====
// ----------------------------------------------------------------------------
// Ordered list positional edit - top level
// Path: request register, then result register; an edit is a parallel shift.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset: list length and both valid flags clear; element contents undefined.
// ----------------------------------------------------------------------------
`include "ordered_list_positional_edit_top_defines.svh"

module ordered_list_positional_edit_top
    import olpe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olpe_in_if.sink    i_in,
    olpe_out_if.source o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // request register
    logic                      r_in_valid;
    t_action                   r_action;
    logic [POS_W-1:0]          r_position;
    logic signed [VALUE_W-1:0] r_value;

    // list state
    logic [VALUE_W-1:0]        r_store [CAPACITY];
    logic [VALUE_W-1:0]        n_store [CAPACITY];
    logic [VALUE_W-1:0]        shift_up   [CAPACITY];
    logic [VALUE_W-1:0]        shift_down [CAPACITY];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    // result register
    logic                      r_out_valid;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_removed;
    logic [LEN_W-1:0]          r_length;

    logic                      exec;
    logic                      full;
    logic                      empty;
    logic                      do_ins;
    logic                      do_rem;
    logic [XW-1:0]             edit_idx;
    logic [XW-1:0]             count_x;
    logic [XW-1:0]             pos_x;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] n_removed;

    assign exec       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action   <= t_action'(i_in.action);
            r_position <= i_in.position;
            r_value    <= i_in.value;
        end
    end

    // decode the edit
    assign full    = (r_count >= CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign count_x = XW'(r_count);
    assign pos_x   = XW'(r_position);

    always_comb begin
        n_status = ST_OK;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        edit_idx = '0;
        unique case (r_action)
            A_PUSH_FRONT: begin
                if (full) n_status = ST_FULL;
                else do_ins = 1'b1;
            end
            A_PUSH_REAR: begin
                edit_idx = count_x;
                if (full) n_status = ST_FULL;
                else do_ins = 1'b1;
            end
            A_POP_FRONT: begin
                if (empty) n_status = ST_EMPTY;
                else do_rem = 1'b1;
            end
            A_POP_REAR: begin
                edit_idx = count_x - XW'(1);
                if (empty) n_status = ST_EMPTY;
                else do_rem = 1'b1;
            end
            A_INSERT_AT: begin
                edit_idx = pos_x - XW'(1);
                if (pos_x == '0 || pos_x > count_x + XW'(1)) n_status = ST_POS;
                else if (full) n_status = ST_FULL;
                else do_ins = 1'b1;
            end
            A_REMOVE_AT: begin
                edit_idx = pos_x - XW'(1);
                if (empty) n_status = ST_EMPTY;
                else if (pos_x == '0 || pos_x > count_x) n_status = ST_POS;
                else do_rem = 1'b1;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // parallel shift of the element array
    for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
        if (i == 0) begin : g_first
            assign shift_up[i] = r_value;
        end else begin : g_rest
            assign shift_up[i] = r_store[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign shift_down[i] = r_store[i];
        end else begin : g_inner
            assign shift_down[i] = r_store[i+1];
        end

        always_comb begin
            n_store[i] = r_store[i];
            if (do_ins) begin
                if (XW'(i) == edit_idx) n_store[i] = r_value;
                else if (XW'(i) > edit_idx) n_store[i] = shift_up[i];
            end else if (do_rem) begin
                if (XW'(i) >= edit_idx) n_store[i] = shift_down[i];
            end
        end
    end

    assign n_removed = do_rem ? $signed(r_store[edit_idx[IW-1:0]]) : '0;

    always_comb begin
        n_count = r_count;
        if (do_ins) n_count = r_count + CW'(1);
        else if (do_rem) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_length  <= LEN_W'(n_count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_removed;
    assign o_out.length        = r_length;

    `OLPE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY),
        "list length above capacity")
    `OLPE_ASSERT_NEXT(a_insert_grows, exec && do_ins,
        r_count == $past(r_count) + CW'(1), "insert did not grow list")
    `OLPE_ASSERT_NEXT(a_remove_shrinks, exec && do_rem,
        r_count == $past(r_count) - CW'(1), "remove did not shrink list")
    `OLPE_ASSERT_NEXT(a_error_holds, exec && n_status != ST_OK,
        $stable(r_count), "failed edit changed list length")
    `OLPE_ASSERT_NOW(a_removed_ok, r_out_valid && r_removed != '0,
        r_status == ST_OK, "removed value reported on failed edit")

endmodule

// ===== bench/ordered_list_positional_edit_top_tb.sv =====
// ----------------------------------------------------------------------------
// Ordered list positional edit - testbench
// Sends list edits over the request channel and tracks the list contents in a
// queue, so that each result transaction is checked field by field as it
// leaves the block. Directed edits cover the empty list, bad positions, full
// list, extreme values and spare edit codes. Fill/drain sweeps and random
// edit mixes follow under three sender/receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_list_positional_edit_top_tb;
    import olpe_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [ACTION_W-1:0] A_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] A_SPARE_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [LEN_W-1:0]          length;
    } t_edit_result;

    logic i_clk;
    logic i_rst_n;

    olpe_in_if  in_ch ();
    olpe_out_if out_ch ();

    ordered_list_positional_edit_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic signed [VALUE_W-1:0] list_shadow[$];
    t_edit_result              pending_results[$];

    int    src_idle_pct;
    int    snk_idle_pct;
    int    fail_count;
    int    sent_count;
    int    checked_count;
    int    status_seen[4];
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_edit_result predict_edit(input logic [ACTION_W-1:0] act,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [VALUE_W-1:0] val);
        t_edit_result r;
        int           count;
        bit           full;
        bit           empty;
        count = list_shadow.size();
        full  = count >= CAPACITY;
        empty = count == 0;
        r.status        = ST_OK;
        r.removed_value = '0;
        case (act)
            A_PUSH_FRONT: begin
                if (full) r.status = ST_FULL;
                else list_shadow.push_front(val);
            end
            A_PUSH_REAR: begin
                if (full) r.status = ST_FULL;
                else list_shadow.push_back(val);
            end
            A_POP_FRONT: begin
                if (empty) r.status = ST_EMPTY;
                else r.removed_value = list_shadow.pop_front();
            end
            A_POP_REAR: begin
                if (empty) r.status = ST_EMPTY;
                else r.removed_value = list_shadow.pop_back();
            end
            A_INSERT_AT: begin
                if (pos < 1 || pos > count + 1) r.status = ST_POS;
                else if (full) r.status = ST_FULL;
                else list_shadow.insert(pos - 1, val);
            end
            A_REMOVE_AT: begin
                if (empty) r.status = ST_EMPTY;
                else if (pos < 1 || pos > count) r.status = ST_POS;
                else begin
                    r.removed_value = list_shadow[pos - 1];
                    list_shadow.delete(pos - 1);
                end
            end
            default: ;
        endcase
        r.length = LEN_W'(list_shadow.size());
        return r;
    endfunction

    task automatic send_edit(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                             input logic signed [VALUE_W-1:0] val);
        t_edit_result r;
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.position <= pos;
        in_ch.value    <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = predict_edit(act, pos, val);
        pending_results.push_back(r);
        status_seen[r.status]++;
        sent_count++;
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_result();
        t_edit_result exp_r;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result transaction: status %0d removed %0d length %0d",
                     $time, out_ch.status, out_ch.removed_value, out_ch.length);
            fail_count++;
        end else begin
            exp_r = pending_results.pop_front();
            checked_count++;
            if (out_ch.status !== exp_r.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp_r.status, out_ch.status);
                fail_count++;
            end
            if (out_ch.removed_value !== exp_r.removed_value) begin
                $display("%0t: removed value mismatch, expected %0d, actual %0d",
                         $time, exp_r.removed_value, out_ch.removed_value);
                fail_count++;
            end
            if (out_ch.length !== exp_r.length) begin
                $display("%0t: length mismatch, expected %0d, actual %0d",
                         $time, exp_r.length, out_ch.length);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) check_result();
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("[ordered_list_positional_edit_top] ERROR");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [ACTION_W-1:0] act);
        int top;
        top = (act == A_INSERT_AT) ? list_shadow.size() + 1 : list_shadow.size();
        case ($urandom_range(9))
            0: return '0;
            1: return POS_W'(top + 1);
            2: return POS_W'($urandom_range(63));
            default: return (top == 0) ? '0 : POS_W'($urandom_range(top, 1));
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_insert_action();
        case ($urandom_range(2))
            0: return A_PUSH_FRONT;
            1: return A_PUSH_REAR;
            default: return A_INSERT_AT;
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_remove_action();
        case ($urandom_range(2))
            0: return A_POP_FRONT;
            1: return A_POP_REAR;
            default: return A_REMOVE_AT;
        endcase
    endfunction

    task automatic test_empty_list();
        send_edit(A_POP_FRONT, 6'd1, pick_value());
        send_edit(A_POP_REAR, 6'd0, pick_value());
        send_edit(A_REMOVE_AT, 6'd0, pick_value());
        send_edit(A_REMOVE_AT, 6'd63, pick_value());
        send_edit(A_INSERT_AT, 6'd0, pick_value());
        send_edit(A_INSERT_AT, 6'd2, pick_value());
    endtask

    task automatic test_positions_and_extremes();
        send_edit(A_INSERT_AT, 6'd1, VALUE_MIN);
        send_edit(A_PUSH_REAR, 6'd63, VALUE_MAX);
        send_edit(A_PUSH_FRONT, 6'd0, '0);
        send_edit(A_INSERT_AT, 6'd4, -1);
        send_edit(A_INSERT_AT, 6'd3, $urandom);
        send_edit(A_REMOVE_AT, 6'd6, pick_value());
        send_edit(A_INSERT_AT, 6'd7, pick_value());
        send_edit(A_REMOVE_AT, 6'd5, pick_value());
        send_edit(A_REMOVE_AT, 6'd1, pick_value());
        send_edit(A_POP_REAR, 6'd0, pick_value());
        send_edit(A_POP_FRONT, 6'd0, pick_value());
        send_edit(A_REMOVE_AT, 6'd1, pick_value());
    endtask

    task automatic test_spare_actions();
        send_edit(A_SPARE_LO, POS_W'($urandom_range(63)), pick_value());
        send_edit(A_SPARE_HI, POS_W'($urandom_range(63)), pick_value());
        send_edit(A_PUSH_REAR, 6'd0, pick_value());
        send_edit(A_SPARE_HI, 6'd1, pick_value());
        send_edit(A_POP_FRONT, 6'd0, pick_value());
    endtask

    task automatic test_fill_and_drain();
        logic [ACTION_W-1:0] act;
        while (list_shadow.size() < CAPACITY) begin
            act = pick_insert_action();
            send_edit(act, (act == A_INSERT_AT) ? POS_W'($urandom_range(list_shadow.size() + 1, 1))
                                                : POS_W'($urandom_range(63)), pick_value());
        end
        send_edit(A_PUSH_FRONT, POS_W'($urandom_range(63)), pick_value());
        send_edit(A_PUSH_REAR, POS_W'($urandom_range(63)), pick_value());
        send_edit(A_INSERT_AT, POS_W'(CAPACITY + 1), pick_value());
        send_edit(A_INSERT_AT, POS_W'(CAPACITY + 2), pick_value());
        send_edit(A_INSERT_AT, '0, pick_value());
        send_edit(A_REMOVE_AT, POS_W'(CAPACITY + 1), pick_value());
        send_edit(A_REMOVE_AT, POS_W'(CAPACITY), pick_value());
        while (list_shadow.size() > 0) begin
            act = pick_remove_action();
            send_edit(act, (act == A_REMOVE_AT) ? POS_W'($urandom_range(list_shadow.size(), 1))
                                                : POS_W'($urandom_range(63)), pick_value());
        end
        send_edit(A_REMOVE_AT, POS_W'($urandom_range(63)), pick_value());
        send_edit(A_POP_REAR, POS_W'($urandom_range(63)), pick_value());
    endtask

    task automatic test_random_edits(input int n_edits);
        logic [ACTION_W-1:0] act;
        int                  grow_pct;
        grow_pct = 70;
        repeat (n_edits) begin
            if (list_shadow.size() >= CAPACITY) grow_pct = 30;
            else if (list_shadow.size() == 0) grow_pct = 70;
            else if ($urandom_range(99) < 5) grow_pct = 100 - grow_pct;
            if ($urandom_range(99) < 4) act = $urandom_range(1) ? A_SPARE_HI : A_SPARE_LO;
            else if ($urandom_range(99) < grow_pct) act = pick_insert_action();
            else act = pick_remove_action();
            send_edit(act, pick_position(act), pick_value());
        end
    endtask

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.action   = A_PUSH_FRONT;
        in_ch.position = '0;
        in_ch.value    = '0;
        out_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        fail_count     = 0;
        sent_count     = 0;
        checked_count  = 0;
        cycle_count    = 0;
        foreach (status_seen[k]) status_seen[k] = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 35;
        snk_idle_pct = 55;
        test_empty_list();
        test_positions_and_extremes();
        test_spare_actions();
        wait_all_results();
        test_fill_and_drain();
        test_random_edits(65);
        wait_all_results();

        src_idle_pct = 55;
        snk_idle_pct = 35;
        test_fill_and_drain();
        test_random_edits(65);
        wait_all_results();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_fill_and_drain();
        test_random_edits(70);
        wait_all_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Edits sent %0d, results checked %0d over three idle mixes", sent_count,
                 checked_count);
        $display("Outcomes: ok %0d, empty %0d, bad position %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_POS],
                 status_seen[ST_FULL]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[ordered_list_positional_edit_top] OK");
        end else begin
            $display("[ordered_list_positional_edit_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/olpe_pkg.sv
rtl/olpe_ifs.sv
rtl/ordered_list_positional_edit_top.sv
bench/ordered_list_positional_edit_top_tb.sv
